// ===== sv/ehtc_pkg.sv =====
package ehtc_pkg;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CLICKS_PER_DEG = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEG_PER_CLICK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_ADVANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR_FACTOR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_TOL       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_TIMEOUT  = 3'd5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] MODE_FLOAT = 2'd0;
   localparam logic [1:0] MODE_DRIVE = 2'd1;
   localparam logic [1:0] MODE_BRAKE = 2'd2;

   // floor(2^34 / 90), used for the divide by 23040 = 256 * 90
   localparam logic [27:0] RECIP_90 = 28'd190887435;
   localparam logic [28:0] DIV_90   = 29'd90;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SUM  = 8'b0000_0010,
      ST_MUL  = 8'b0000_0100,
      ST_NRM  = 8'b0000_1000,
      ST_REC  = 8'b0001_0000,
      ST_CLK  = 8'b0010_0000,
      ST_DEC  = 8'b0100_0000,
      ST_RSP  = 8'b1000_0000
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic do_sum;
      logic do_mul;
      logic do_nrm;
      logic do_rec;
      logic do_clk;
      logic commit;
   } ctl_cmd_type;

endpackage

// ===== sv/encoder_heading_turn_controller.sv =====
// a tick request steps through the six-step sequencer over the multiply and
// divide-by-constant datapath, then holds its response until rsp_tready;
// no new request is taken until that response has been accepted
// load requests are taken only while idle and give no response
// reset: synchronous active high, turn idle, configuration and turn state at defaults
module encoder_heading_turn_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // turn_degrees, corrections_allowed, command_id, heading, front_left_count,
   // front_right_count, back_right_count, back_left_count, time_ms, zero pad
   input  logic [ehtc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // motor_mode, turn_negative, reset_encoders, finished, complete_valid,
   // complete_id, correction_started, zero pad
   output logic [ehtc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ehtc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ehtc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ehtc_pkg::*;

   ctl_cmd_type cmd;

   ehtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ehtc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ===== sv/ehtc_ctrl.sv =====
module ehtc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_op,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output ehtc_pkg::ctl_cmd_type cmd
);
   import ehtc_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RSP);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.capture = accept && (req_op == OP_TICK);
      cmd.load    = accept && (req_op == OP_LOAD);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.do_sum = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_NRM;
         end
         ST_NRM: begin
            cmd.do_nrm = 1'b1;
            state_in   = ST_REC;
         end
         ST_REC: begin
            cmd.do_rec = 1'b1;
            state_in   = ST_CLK;
         end
         ST_CLK: begin
            cmd.do_clk = 1'b1;
            state_in   = ST_DEC;
         end
         ST_DEC: begin
            cmd.commit = 1'b1;
            state_in   = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/ehtc_datapath.sv =====
module ehtc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ehtc_pkg::ctl_cmd_type               cmd,
   input  logic [ehtc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [ehtc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ehtc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ehtc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ehtc_pkg::*;

   // configuration
   logic [15:0]        cpd_ff, dpc_ff, tol_ff, tmo_ff;
   logic [6:0]         adv_ff;
   logic signed [15:0] cf_ff;

   // turn state
   logic signed [10:0] pending_ff, pending_in;
   logic [15:0]        corr_left_ff, corr_left_in;
   logic signed [15:0] report_ff, report_in;
   logic               begun_ff, begun_in;
   logic               braking_ff, braking_in;
   logic [8:0]         start_ff, start_in;
   logic [9:0]         target_ff, target_in;
   logic signed [23:0] click_ff, click_in;
   logic [17:0]        prev_ff, prev_in;
   logic [31:0]        bst_ff, bst_in;

   // captured tick
   logic [8:0]         head_ff;
   logic signed [15:0] cnt_ff [4];
   logic [31:0]        time_ff;

   // stage registers
   logic [17:0]        sum_ff, sum_in;
   logic [10:0]        a_ff, a_in;
   logic [8:0]         dest_ff, dest_in;
   logic signed [23:0] sq_ff, sq_in;
   logic signed [39:0] p_ff, p_in;
   logic [26:0]        ac_ff, ac_in;
   logic signed [42:0] md_ff, md_in;
   logic               ge_tol_ff, ge_tol_in;
   logic [27:0]        n_ff, n_in;
   logic               psign_ff;
   logic [55:0]        m_ff, m_in;
   logic signed [23:0] cnew_ff, cnew_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   assign rsp_tdata = rsp_ff;

   // sum of magnitudes, wrapped destination, square term
   logic signed [16:0] c17 [4];
   logic [16:0]        cabs [4];
   logic signed [12:0] d13;
   logic [11:0]        t12;
   logic signed [11:0] a_s;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         c17[i]  = 17'(cnt_ff[i]);
         cabs[i] = c17[i] < 0 ? 17'(-c17[i]) : 17'(c17[i]);
      end
      sum_in = 18'(cabs[0]) + 18'(cabs[1]) + 18'(cabs[2]) + 18'(cabs[3]);
      a_in   = pending_ff < 0 ? 11'(-12'(pending_ff)) : 11'(pending_ff);
      d13    = 13'(pending_ff) + signed'(13'({4'b0, head_ff}))
             + (pending_ff >= 0 ? -signed'(13'({6'b0, adv_ff}))
                                :  signed'(13'({6'b0, adv_ff})));
      t12    = 12'(d13 + 13'sd1440);
      if (t12 >= 12'd2880) t12 = t12 - 12'd2880;
      if (t12 >= 12'd1440) t12 = t12 - 12'd1440;
      if (t12 >= 12'd720)  t12 = t12 - 12'd720;
      if (t12 >= 12'd360)  t12 = t12 - 12'd360;
      dest_in = t12[8:0];
      a_s     = signed'({1'b0, a_in});
      sq_in   = 24'(a_s - 12'sd180) * 24'(a_s);
   end

   // products and miss
   logic signed [25:0] miss, mdir, amiss;
   always_comb begin
      p_in   = 40'(sq_ff) * 40'(cf_ff);
      ac_in  = 27'(a_ff) * 27'(cpd_ff);
      miss   = 26'(click_ff) - signed'(26'({8'b0, sum_ff}));
      mdir   = pending_ff >= 0 ? miss : -miss;
      amiss  = miss < 0 ? -miss : miss;
      ge_tol_in = 26'(amiss) >= {10'b0, tol_ff};
      md_in  = 43'(mdir) * signed'(43'({1'b0, dpc_ff}));
   end

   // normalize, reciprocal, click target
   logic [39:0]        pabs;
   logic [21:0]        q0, q;
   logic [28:0]        r29;
   logic signed [22:0] corr;
   logic signed [31:0] num;
   always_comb begin
      pabs    = p_ff < 0 ? 40'(-p_ff) : 40'(p_ff);
      n_in    = pabs[35:8];
      m_in    = 56'(n_ff) * 56'(RECIP_90);
      q0      = m_ff[55:34];
      r29     = 29'(n_ff) - 29'(29'(q0) * DIV_90);
      q       = r29 >= DIV_90 ? q0 + 22'd1 : q0;
      corr    = psign_ff ? -signed'({1'b0, q}) : signed'({1'b0, q});
      num     = signed'(32'({5'b0, ac_ff})) + (32'(corr) <<< 8);
      cnew_in = num < 0 ? 24'((num + 32'sd255) >>> 8) : 24'(num >>> 8);
   end

   // decision
   logic               eff_braking;
   logic [8:0]         eff_start;
   logic [9:0]         eff_target;
   logic signed [23:0] eff_click;
   logic signed [11:0] span;
   logic               reached, stop;
   logic signed [42:0] ndt;
   logic signed [10:0] nd;
   logic [1:0]         mode;
   logic               rst, fin, cv, cs;
   logic [14:0]        cid;

   always_comb begin
      pending_in   = pending_ff;
      corr_left_in = corr_left_ff;
      report_in    = report_ff;
      begun_in     = begun_ff;
      braking_in   = braking_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      click_in     = click_ff;
      prev_in      = prev_ff;
      bst_in       = bst_ff;
      mode = MODE_FLOAT;
      rst  = 1'b0;
      fin  = 1'b0;
      cv   = 1'b0;
      cs   = 1'b0;
      cid  = '0;
      eff_braking = braking_ff;
      eff_start   = start_ff;
      eff_target  = target_ff;
      eff_click   = click_ff;
      reached     = 1'b0;
      span        = '0;
      ndt = md_ff < 0 ? (md_ff + 43'sd1023) >>> 10 : md_ff >>> 10;
      if (ndt > 43'sd1023) nd = 11'sd1023;
      else if (ndt < -43'sd1024) nd = -11'sd1024;
      else nd = 11'(ndt);
      stop = (sum_ff < prev_ff) || (a_ff < 11'd3)
          || ((time_ff - bst_ff) > {16'b0, tmo_ff});

      if (cmd.load) begin
         pending_in   = signed'(req_tdata[10:0]);
         corr_left_in = req_tdata[26:11];
         report_in    = signed'(req_tdata[42:27]);
         begun_in     = 1'b0;
         braking_in   = 1'b0;
      end else if (cmd.commit) begin
         if (!begun_ff && pending_ff == 0) begin
            fin = 1'b1;
            if (report_ff >= 0) begin
               cv        = 1'b1;
               cid       = report_ff[14:0];
               report_in = -16'sd1;
            end
         end else begin
            if (!begun_ff) begin
               begun_in    = 1'b1;
               braking_in  = 1'b0;
               eff_braking = 1'b0;
               eff_start   = head_ff;
               eff_target  = {1'b0, dest_ff};
               eff_click   = cnew_ff;
               start_in    = head_ff;
               target_in   = {1'b0, dest_ff};
               click_in    = cnew_ff;
               prev_in     = '0;
               rst         = 1'b1;
            end
            if (eff_braking) begin
               if (stop) begin
                  fin = 1'b1;
                  if (ge_tol_ff && corr_left_ff != 0) begin
                     pending_in   = nd;
                     corr_left_in = corr_left_ff - 16'd1;
                     begun_in     = 1'b0;
                     braking_in   = 1'b0;
                     cs           = 1'b1;
                  end else begin
                     if (report_ff >= 0) begin
                        cv  = 1'b1;
                        cid = report_ff[14:0];
                     end
                     pending_in   = '0;
                     corr_left_in = '0;
                     report_in    = -16'sd1;
                     begun_in     = 1'b0;
                     braking_in   = 1'b0;
                  end
               end else begin
                  prev_in = sum_ff;
                  mode    = MODE_BRAKE;
               end
            end else begin
               span = signed'(12'({3'b0, eff_start})) + 12'(pending_ff);
               if (pending_ff > 0) begin
                  if (span < 12'sd360) reached = {1'b0, head_ff} >= eff_target;
                  else reached = head_ff < 9'd180 && {1'b0, head_ff} >= eff_target;
               end else begin
                  if (span >= 0) reached = {1'b0, head_ff} <= eff_target;
                  else reached = head_ff >= 9'd180 && {1'b0, head_ff} <= eff_target;
               end
               if (signed'(25'({7'b0, sum_ff})) >= 25'(eff_click)) reached = 1'b1;
               if (reached) begin
                  braking_in = 1'b1;
                  prev_in    = sum_ff;
                  bst_in     = time_ff;
                  mode       = MODE_BRAKE;
               end else begin
                  mode = MODE_DRIVE;
               end
            end
         end
      end
      rsp_in = {2'b0, cs, cid, cv, fin, rst, (pending_ff <= 0), mode};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpd_ff       <= 16'd512;
         dpc_ff       <= 16'd128;
         adv_ff       <= 7'd10;
         cf_ff        <= '0;
         tol_ff       <= 16'd20;
         tmo_ff       <= 16'd500;
         pending_ff   <= '0;
         corr_left_ff <= '0;
         report_ff    <= -16'sd1;
         begun_ff     <= 1'b0;
         braking_ff   <= 1'b0;
         start_ff     <= '0;
         target_ff    <= '0;
         click_ff     <= '0;
         prev_ff      <= '0;
         bst_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CLICKS_PER_DEG: cpd_ff <= csr_wdata;
               CSR_DEG_PER_CLICK:  dpc_ff <= csr_wdata;
               CSR_BRAKE_ADVANCE:  adv_ff <= csr_wdata[6:0];
               CSR_CORR_FACTOR:    cf_ff  <= signed'(csr_wdata);
               CSR_MISS_TOL:       tol_ff <= csr_wdata;
               CSR_BRAKE_TIMEOUT:  tmo_ff <= csr_wdata;
               default: ;
            endcase
         end
         pending_ff   <= pending_in;
         corr_left_ff <= corr_left_in;
         report_ff    <= report_in;
         begun_ff     <= begun_in;
         braking_ff   <= braking_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         click_ff     <= click_in;
         prev_ff      <= prev_in;
         bst_ff       <= bst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         head_ff   <= req_tdata[51:43];
         cnt_ff[0] <= signed'(req_tdata[67:52]);
         cnt_ff[1] <= signed'(req_tdata[83:68]);
         cnt_ff[2] <= signed'(req_tdata[99:84]);
         cnt_ff[3] <= signed'(req_tdata[115:100]);
         time_ff   <= req_tdata[147:116];
      end
      if (cmd.do_sum) begin
         sum_ff  <= sum_in;
         a_ff    <= a_in;
         dest_ff <= dest_in;
         sq_ff   <= sq_in;
      end
      if (cmd.do_mul) begin
         p_ff      <= p_in;
         ac_ff     <= ac_in;
         md_ff     <= md_in;
         ge_tol_ff <= ge_tol_in;
      end
      if (cmd.do_nrm) begin
         n_ff     <= n_in;
         psign_ff <= p_ff < 0;
      end
      if (cmd.do_rec) m_ff <= m_in;
      if (cmd.do_clk) cnew_ff <= cnew_in;
      if (cmd.commit) rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/ehtc_checker.sv =====
module ehtc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [0:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ehtc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ehtc_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while response pending");

   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == OP_TICK |=> !rsp_tvalid)
      else $error("response too early after tick");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("illegal motor mode");

endmodule

bind encoder_heading_turn_controller ehtc_checker u_ehtc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ehtc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic [1:0]  mode;
      logic        neg;
      logic        rst;
      logic        fin;
      logic        cv;
      logic [14:0] cid;
      logic        cs;
   } turn_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   encoder_heading_turn_controller u_dut (.*);

   always #10 clock = ~clock;

   // predictor copy of registers and turn state
   int unsigned cpd, dpc, adv, tol, tmo;
   int cf;
   int pend_deg;
   int unsigned corr_left;
   int rep_id;
   bit begun, braking;
   int start_hd, target_hd, clk_target, prev_sum;
   bit [31:0] brake_t0;

   turn_rsp_type turn_rsp_q[$];
   int errors = 0;
   int sent = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   bit [31:0] now_ms = 0;

   function automatic int iabs(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void clear_turn();
      pend_deg = 0; corr_left = 0; rep_id = -1; begun = 0; braking = 0;
   endfunction

   function automatic void apply_cfg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
         CSR_CLICKS_PER_DEG: cpd = v;
         CSR_DEG_PER_CLICK:  dpc = v;
         CSR_BRAKE_ADVANCE:  adv = v[6:0];
         CSR_CORR_FACTOR:    cf = $signed(v);
         CSR_MISS_TOL:       tol = v;
         CSR_BRAKE_TIMEOUT:  tmo = v;
         default: ;
      endcase
   endfunction

   function automatic void step_turn(logic op, logic [REQ_DATA_W-1:0] d);
      turn_rsp_type r;
      int deg, head, sum, a, dest, miss;
      longint corr, num, m, nd;
      bit reached, done;
      r = '{default: '0};
      done = 0;
      if (op == OP_LOAD) begin
         pend_deg = $signed(d[10:0]);
         corr_left = d[26:11];
         rep_id = $signed(d[42:27]);
         begun = 0;
         braking = 0;
         return;
      end
      deg = pend_deg;
      head = d[51:43];
      sum = iabs($signed(d[67:52])) + iabs($signed(d[83:68])) +
            iabs($signed(d[99:84])) + iabs($signed(d[115:100]));
      if (!begun) begin
         a = iabs(deg);
         if (deg == 0) begin
            r.fin = 1;
            if (rep_id > -1) begin
               r.cv = 1;
               r.cid = rep_id[14:0];
               rep_id = -1;
            end
            done = 1;
         end else begin
            begun = 1;
            braking = 0;
            start_hd = head;
            dest = deg + head + (deg >= 0 ? -int'(adv) : int'(adv));
            dest = dest % 360;
            if (dest < 0) dest += 360;
            target_hd = dest;
            corr = (longint'(a - 180) * a * cf) / 23040;
            num = longint'(a) * longint'(cpd) + corr * 256;
            clk_target = int'(num / 256);
            prev_sum = 0;
            r.rst = 1;
         end
      end
      if (!done && braking) begin
         if (sum < prev_sum || iabs(deg) < 3 || (d[147:116] - brake_t0) > tmo) begin
            miss = clk_target - sum;
            r.fin = 1;
            if (iabs(miss) >= tol && corr_left > 0) begin
               m = deg >= 0 ? miss : -miss;
               nd = (m * longint'(dpc)) / 1024;
               if (nd > 1023) nd = 1023;
               if (nd < -1024) nd = -1024;
               pend_deg = int'(nd);
               corr_left -= 1;
               begun = 0;
               braking = 0;
               r.cs = 1;
            end else begin
               if (rep_id > -1) begin
                  r.cv = 1;
                  r.cid = rep_id[14:0];
               end
               clear_turn();
            end
         end else begin
            prev_sum = sum;
            r.mode = MODE_BRAKE;
         end
         done = 1;
      end
      if (!done) begin
         if (deg > 0) begin
            if (start_hd + deg < 360) reached = head >= target_hd;
            else reached = head < 180 && head >= target_hd;
         end else begin
            if (start_hd + deg >= 0) reached = head <= target_hd;
            else reached = head >= 180 && head <= target_hd;
         end
         if (sum >= clk_target) reached = 1;
         if (reached) begin
            braking = 1;
            prev_sum = sum;
            brake_t0 = d[147:116];
            r.mode = MODE_BRAKE;
         end else begin
            r.mode = MODE_DRIVE;
         end
      end
      r.neg = deg <= 0;
      turn_rsp_q.push_back(r);
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(int deg, int ncorr, int id, int head,
         int fl, int fr, int br, int bl, bit [31:0] t);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[10:0] = 11'(deg);
      d[26:11] = 16'(ncorr);
      d[42:27] = 16'(id);
      d[51:43] = 9'(head);
      d[67:52] = 16'(fl);
      d[83:68] = 16'(fr);
      d[99:84] = 16'(br);
      d[115:100] = 16'(bl);
      d[147:116] = t;
      return d;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_tready = 1'b0;
      else rsp_tready = (pick_gap() == 0);
   end

   always @(posedge clock) begin
      turn_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (turn_rsp_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            e = turn_rsp_q.pop_front();
            if (rsp_tdata[1:0] !== e.mode || rsp_tdata[2] !== e.neg ||
                rsp_tdata[3] !== e.rst || rsp_tdata[4] !== e.fin ||
                rsp_tdata[5] !== e.cv || rsp_tdata[20:6] !== e.cid ||
                rsp_tdata[21] !== e.cs || rsp_tdata[23:22] !== 2'b00) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp mode %0d neg %0d rst %0d fin %0d cv %0d",
                            " id %0d cs %0d, got %h"},
                           e.mode, e.neg, e.rst, e.fin, e.cv, e.cid, e.cs, rsp_tdata);
            end
         end
      end
   end

   task automatic send(logic op, logic [REQ_DATA_W-1:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tuser = op;
      req_tdata = d;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      step_turn(op, d);
      sent++;
   endtask

   task automatic load(int deg, int ncorr, int id);
      send(OP_LOAD, pack_req(deg, ncorr, id, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic tick(int head, int fl, int fr, int br, int bl, bit [31:0] t);
      send(OP_TICK, pack_req(0, 0, 0, head, fl, fr, br, bl, t));
   endtask

   task automatic drain();
      @(negedge clock) req_tvalid = 1'b0;
      while (turn_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_cfg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock) csr_we = 1'b0;
      apply_cfg(idx, v);
   endtask

   task automatic set_cfg(int c0, int c1, int c2, int c3, int c4, int c5);
      drain();
      write_cfg(CSR_CLICKS_PER_DEG, 16'(c0));
      write_cfg(CSR_DEG_PER_CLICK, 16'(c1));
      write_cfg(CSR_BRAKE_ADVANCE, 16'(c2));
      write_cfg(CSR_CORR_FACTOR, 16'(c3));
      write_cfg(CSR_MISS_TOL, 16'(c4));
      write_cfg(CSR_BRAKE_TIMEOUT, 16'(c5));
   endtask

   // load a turn, then tick it through drive and brake until the turn ends or 60 ticks are sent
   task automatic run_turn(int deg, int ncorr, int id);
      int head, c, n, fl, fr, br, bl;
      load(deg, ncorr, id);
      head = $urandom_range(0, 359);
      c = 0;
      n = 0;
      do begin
         if (!braking) begin
            head = (head + (pend_deg > 0 ? 1 : -1) * $urandom_range(0, 30) + 360) % 360;
            c += $urandom_range(0, 40);
            now_ms += $urandom_range(1, 20);
         end else if ($urandom_range(0, 3) == 0) begin
            c = c > 5 ? c - $urandom_range(1, 5) : 0;
         end else begin
            c += $urandom_range(0, 3);
            now_ms += ($urandom_range(0, 7) == 0) ? $urandom_range(100, 70000) : 5;
         end
         if (c > 32767) c = 32767;
         fl = $urandom_range(0, 1) ? c : -c;
         fr = c;
         br = $urandom_range(0, 1) ? -c : c;
         bl = c;
         tick(head, fl, fr, br, bl, now_ms);
         n++;
      end while ((pend_deg != 0 || begun) && n < 60);
   endtask

   task automatic noise_item();
      logic [REQ_DATA_W-1:0] d;
      d = REQ_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      d[151:148] = '0;
      send(logic'($urandom_range(0, 1)), d);
   endtask

   task automatic test_directed();
      tick(0, 0, 0, 0, 0, 0);
      load(0, 0, 32767);
      tick(359, 0, 0, 0, 0, 1);
      tick(359, 0, 0, 0, 0, 2);
      load(0, 0, -1);
      tick(511, -32768, 32767, -32768, 32767, 32'hFFFF_FFFF);
      load(2, 0, 5);
      tick(10, 0, 0, 0, 0, 32'hFFFF_FFF0);
      tick(12, 1, 1, 1, 1, 32'h0000_0010);
      load(1023, 65535, 0);
      tick(511, 0, 0, 0, 0, 100);
      tick(511, -32768, -32768, -32768, -32768, 200);
      tick(0, 0, 0, 0, 0, 300);
      load(-1024, 1, 77);
      tick(0, 0, 0, 0, 0, 400);
      tick(200, 10, 10, 10, 10, 500);
      tick(200, 5, 5, 5, 5, 600);
      tick(200, 0, 0, 0, 0, 700);
      load(-2, 0, 3);
      tick(5, 0, 0, 0, 0, 800);
      tick(5, 0, 0, 0, 0, 900);
      run_turn(350, 3, 1234);
      run_turn(-350, 3, 4321);
   endtask

   task automatic test_turns(int count);
      int deg;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            noise_item();
         end else begin
            deg = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2047)) - 1024
                                              : int'($urandom_range(0, 200)) - 100;
            run_turn(deg, $urandom_range(0, 3), int'($urandom_range(0, 32768)) - 1);
         end
      end
   endtask

   task automatic test_pressure();
      drain();
      quiet = 1'b1;
      test_turns(5);
      quiet = 1'b0;
      drain();
      test_turns(5);
   endtask

   initial begin
      cpd = 512; dpc = 128; adv = 10; cf = 0; tol = 20; tmo = 500;
      clear_turn();
      start_hd = 0; target_hd = 0; clk_target = 0; prev_sum = 0; brake_t0 = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      test_directed();
      test_turns(15);
      set_cfg(1, 65535, 90, -32768, 0, 0);
      test_directed();
      test_turns(10);
      set_cfg(65535, 1, 0, 32767, 65535, 65535);
      test_directed();
      test_turns(10);
      set_cfg(300, 900, 20, 2000, 5, 200);
      test_pressure();
      while (sent < 950) begin
         set_cfg($urandom_range(1, 1024), $urandom_range(1, 2048), $urandom_range(0, 90),
                 int'($urandom_range(0, 65535)), $urandom_range(0, 60),
                 $urandom_range(0, 1000));
         test_turns(10);
      end

      drain();
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ehtc_pkg.sv
sv/ehtc_ctrl.sv
sv/ehtc_datapath.sv
sv/encoder_heading_turn_controller.sv
sv/ehtc_checker.sv
verif/tb.sv
